FILE: sv/btr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btr_pkg
// Shared item types, codes and the color escape parser for the bitmap text
// renderer.
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam logic [1:0] OP_BEGIN    = 2'd0;
  localparam logic [1:0] OP_CHAR     = 2'd1;
  localparam logic [1:0] OP_LOAD_ROW = 2'd2;
  localparam logic [1:0] OP_LOAD_WID = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OFF_BOTTOM = 2'd1;
  localparam logic [1:0] ST_BAD_ESC    = 2'd2;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h80;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_RBR    = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  localparam logic [15:0] COLOR_MASK = 16'h7FFF;
  localparam logic [2:0]  MAX_DIGITS = 3'd4;
  localparam logic [3:0]  MAX_WIDTH  = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BRACKET,
    PH_ZERO,
    PH_X,
    PH_DIGITS
  } esc_phase_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic [15:0] start_color;
    logic [6:0]  glyph_index;
    logic [2:0]  row_index;
    logic [7:0]  font_data;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] pixel_address;
    logic [15:0] pixel_color;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       row_we;
    logic       row_re;
    logic       wid_we;
    logic       wid_re;
    logic [6:0] glyph;
    logic [2:0] row;
    logic [7:0] data;
  } font_req_t;

  typedef struct packed {
    esc_phase_t  phase;
    logic [15:0] hex;
    logic [2:0]  cnt;
    logic [15:0] color;
    logic        bad;
  } esc_t;

  function automatic esc_t esc_step(input esc_t s, input logic [7:0] c);
    esc_t       r;
    logic       hv;
    logic [3:0] hd;
    r     = s;
    r.bad = 1'b0;
    hv    = 1'b1;
    hd    = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      hd = 4'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      hd = 4'(c - CH_LO_A + 8'd10);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      hd = 4'(c - CH_UP_A + 8'd10);
    end else begin
      hv = 1'b0;
    end
    case (s.phase)
      PH_BRACKET: begin
        if (c == CH_LBR) r.phase = PH_ZERO; else r.bad = 1'b1;
      end
      PH_ZERO: begin
        if (c == CH_ZERO) r.phase = PH_X; else r.bad = 1'b1;
      end
      PH_X: begin
        if (c == CH_X) r.phase = PH_DIGITS; else r.bad = 1'b1;
      end
      default: begin
        if (c == CH_RBR) begin
          if (s.cnt == 3'd0) r.bad = 1'b1;
          else r.color = s.hex & COLOR_MASK;
          r.phase = PH_IDLE;
        end else if (!hv || s.cnt >= MAX_DIGITS) begin
          r.bad   = 1'b1;
          r.phase = PH_IDLE;
        end else begin
          r.hex = {s.hex[11:0], hd};
          r.cnt = s.cnt + 3'd1;
        end
      end
    endcase
    if (r.bad) r.phase = PH_IDLE;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/btr_font_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btr_font_mem
// Glyph row store and glyph width store, one synchronous port each with a
// registered read.
// ----------------------------------------------------------------------------
module btr_font_mem #(
  parameter int GLYPH_TOTAL = 96
) (
  input  wire logic              clk,
  input  wire btr_pkg::font_req_t req,
  output logic [7:0]             row_rd,
  output logic [3:0]             wid_rd
);
  import btr_pkg::*;

  localparam int ROW_DEPTH = GLYPH_TOTAL * 8;
  localparam int RAW       = $clog2(ROW_DEPTH);
  localparam int GAW       = (GLYPH_TOTAL > 1) ? $clog2(GLYPH_TOTAL) : 1;

  logic [7:0]     rows_mem [ROW_DEPTH];
  logic [3:0]     wid_mem  [GLYPH_TOTAL];
  logic [RAW-1:0] row_addr;
  logic [GAW-1:0] wid_addr;
  logic [7:0]     row_rd_r;
  logic [3:0]     wid_rd_r;

  assign row_addr = RAW'({req.glyph, req.row});
  assign wid_addr = GAW'(req.glyph);
  assign row_rd   = row_rd_r;
  assign wid_rd   = wid_rd_r;

  always_ff @(posedge clk) begin
    if (req.row_we) rows_mem[row_addr] <= req.data;
    if (req.row_re) row_rd_r <= rows_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (req.wid_we) wid_mem[wid_addr] <= (req.data > 8'(MAX_WIDTH)) ? MAX_WIDTH : req.data[3:0];
    if (req.wid_re) wid_rd_r <= wid_mem[wid_addr];
  end

endmodule
`default_nettype wire

FILE: sv/bitmap_text_renderer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_text_renderer
// Character stream to framebuffer pixel writes using a loadable 1bpp font,
// with line wrap, newline and an inline color escape.
// ----------------------------------------------------------------------------
//  channel  direction  payload     transfer when
//  in_      input      in_item_t   in_valid & in_ready
//  out_     output     out_item_t  out_valid & out_ready
//
//  One item at a time. Begin, load and control items finish in the execute state.
//  A drawn glyph takes one font memory read per glyph row and gives one pixel
//  result per cycle while the output is not stalled; a wrap off the bottom
//  ends after the width read without drawing.
//  Reset clears cursor, color, escape and failure; font stores are not cleared.
//  A stalled output holds the item in progress; input is taken again once
//  its last result is in the output register.
// ----------------------------------------------------------------------------
module bitmap_text_renderer #(
  parameter int SCREEN_W    = 240,
  parameter int SCREEN_H    = 160,
  parameter int GLYPH_ROWS  = 8,
  parameter int GLYPH_TOTAL = 96
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire btr_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output btr_pkg::out_item_t     out_data
);
  import btr_pkg::*;

  localparam int XW   = $clog2(SCREEN_W + 264);
  localparam int YW   = $clog2(SCREEN_H + 264);
  localparam int RW   = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int YLIM = SCREEN_H - GLYPH_ROWS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WIDTH,
    S_PLAN,
    S_ROWRD,
    S_SCAN,
    S_FINAL
  } state_t;

  state_t      state_r, state_nxt;
  in_item_t    item_r, item_nxt;
  logic [XW-1:0] cx_r, cx_nxt;
  logic [YW-1:0] cy_r, cy_nxt;
  logic [7:0]  lsx_r, lsx_nxt;
  logic [15:0] color_r, color_nxt;
  esc_phase_t  phase_r, phase_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  fail_r, fail_nxt;
  logic [3:0]  w_r, w_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [15:0] base_r, base_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [15:0] pend_addr_r, pend_addr_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  font_req_t   req;
  logic [7:0]  row_rd;
  logic [3:0]  wid_rd;

  logic        can_push;
  logic [7:0]  c;
  logic [6:0]  g;
  logic        printable;
  esc_t        esc_in, esc_out;
  logic        wrap;
  logic [XW-1:0] dx;
  logic [YW-1:0] dy;
  logic [YW-1:0] cy_lf;
  logic [31:0] base_full;
  logic [2:0]  jsel;

  btr_font_mem #(
    .GLYPH_TOTAL(GLYPH_TOTAL)
  ) u_font_mem (
    .clk   (clk),
    .req   (req),
    .row_rd(row_rd),
    .wid_rd(wid_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_push  = !out_valid_r || out_ready;

  assign c         = item_r.char_code;
  assign g         = 7'(c - CH_SPACE);
  assign printable = (c >= CH_SPACE) && (c < CH_DEL) && (9'(g) < 9'(GLYPH_TOTAL));
  assign esc_in    = '{phase: phase_r, hex: hex_r, cnt: cnt_r, color: color_r, bad: 1'b0};
  assign esc_out   = esc_step(esc_in, c);
  assign cy_lf     = cy_r + YW'(GLYPH_ROWS);

  assign wrap      = ((XW+1)'(cx_r) + (XW+1)'(w_r)) > (XW+1)'(SCREEN_W);
  assign dx        = wrap ? XW'(lsx_r) : cx_r;
  assign dy        = wrap ? cy_lf : cy_r;
  assign base_full = 32'(dy) * 32'(SCREEN_W) + 32'(dx);

  always_comb begin
    jsel = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (bits_r[j]) jsel = 3'(j);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    lsx_nxt       = lsx_r;
    color_nxt     = color_r;
    phase_nxt     = phase_r;
    hex_nxt       = hex_r;
    cnt_nxt       = cnt_r;
    fail_nxt      = fail_r;
    w_nxt         = w_r;
    mask_nxt      = mask_r;
    bits_nxt      = bits_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    req           = '0;
    req.glyph     = g;
    req.row       = 3'(row_r);
    req.data      = item_r.font_data;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (item_r.opcode == OP_CHAR && fail_r == ST_OK && phase_r == PH_IDLE &&
            c != CH_ESC && c != CH_LF && printable) begin
          req.wid_re = 1'b1;
          state_nxt  = S_WIDTH;
        end else if (can_push) begin
          case (item_r.opcode)
            OP_BEGIN: begin
              cx_nxt    = XW'(item_r.start_x);
              cy_nxt    = YW'(item_r.start_y);
              lsx_nxt   = item_r.start_x;
              color_nxt = item_r.start_color;
              phase_nxt = PH_IDLE;
              hex_nxt   = 16'd0;
              cnt_nxt   = 3'd0;
              fail_nxt  = (YW'(item_r.start_y) > YW'(YLIM)) ? ST_OFF_BOTTOM : ST_OK;
            end
            OP_CHAR: begin
              if (fail_r == ST_OK) begin
                if (phase_r != PH_IDLE) begin
                  phase_nxt = esc_out.phase;
                  hex_nxt   = esc_out.hex;
                  cnt_nxt   = esc_out.cnt;
                  color_nxt = esc_out.color;
                  if (esc_out.bad) fail_nxt = ST_BAD_ESC;
                end else if (c == CH_ESC) begin
                  phase_nxt = PH_BRACKET;
                  hex_nxt   = 16'd0;
                  cnt_nxt   = 3'd0;
                end else if (c == CH_LF) begin
                  cy_nxt = cy_lf;
                  cx_nxt = XW'(lsx_r);
                  if (cy_lf > YW'(YLIM)) fail_nxt = ST_OFF_BOTTOM;
                end
              end
            end
            OP_LOAD_ROW: begin
              if (9'(item_r.glyph_index) < 9'(GLYPH_TOTAL) &&
                  4'(item_r.row_index) < 4'(GLYPH_ROWS)) begin
                req.row_we = 1'b1;
              end
              req.glyph = item_r.glyph_index;
              req.row   = item_r.row_index;
            end
            default: begin
              if (9'(item_r.glyph_index) < 9'(GLYPH_TOTAL)) req.wid_we = 1'b1;
              req.glyph = item_r.glyph_index;
            end
          endcase
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{write_valid: 1'b0, pixel_address: 16'd0, pixel_color: 16'd0,
                            status: fail_nxt, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      S_WIDTH: begin
        w_nxt     = wid_rd;
        state_nxt = S_PLAN;
      end

      S_PLAN: begin
        cx_nxt = dx + XW'(w_r);
        cy_nxt = dy;
        if (wrap && dy > YW'(YLIM)) begin
          fail_nxt  = ST_OFF_BOTTOM;
          state_nxt = S_FINAL;
        end else begin
          for (int j = 0; j < 8; j++) begin
            mask_nxt[j] = (4'(j) < w_r) &&
                          (((XW+1)'(dx) + (XW+1)'(j)) < (XW+1)'(SCREEN_W));
          end
          base_nxt   = base_full[15:0];
          row_nxt    = '0;
          req.row    = 3'd0;
          req.row_re = 1'b1;
          state_nxt  = S_ROWRD;
        end
      end

      S_ROWRD: begin
        bits_nxt  = row_rd & mask_r;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (bits_r == 8'd0) begin
          if (row_r == RW'(GLYPH_ROWS - 1)) begin
            state_nxt = S_FINAL;
          end else begin
            row_nxt    = row_r + RW'(1);
            base_nxt   = base_r + 16'(SCREEN_W);
            req.row    = 3'(row_r + RW'(1));
            req.row_re = 1'b1;
            state_nxt  = S_ROWRD;
          end
        end else if (!pend_v_r || can_push) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{write_valid: 1'b1, pixel_address: pend_addr_r,
                              pixel_color: color_r, status: fail_r, last: 1'b0};
          end
          pend_v_nxt     = 1'b1;
          pend_addr_nxt  = base_r + 16'(jsel);
          bits_nxt[jsel] = 1'b0;
        end
      end

      S_FINAL: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_data_nxt = '{write_valid: 1'b1, pixel_address: pend_addr_r,
                             pixel_color: color_r, status: fail_r, last: 1'b1};
          end else begin
            out_data_nxt = '{write_valid: 1'b0, pixel_address: 16'd0, pixel_color: 16'd0,
                             status: fail_r, last: 1'b1};
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cx_r        <= '0;
      cy_r        <= '0;
      lsx_r       <= 8'd0;
      color_r     <= 16'd0;
      phase_r     <= PH_IDLE;
      hex_r       <= 16'd0;
      cnt_r       <= 3'd0;
      fail_r      <= ST_OK;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      lsx_r       <= lsx_nxt;
      color_r     <= color_nxt;
      phase_r     <= phase_nxt;
      hex_r       <= hex_nxt;
      cnt_r       <= cnt_nxt;
      fail_r      <= fail_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r      <= item_nxt;
    w_r         <= w_nxt;
    mask_r      <= mask_nxt;
    bits_r      <= bits_nxt;
    row_r       <= row_nxt;
    base_r      <= base_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("pixel still pending while idle");

  a_pixel_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.write_valid |-> out_data_r.status == ST_OK)
    else $error("pixel write under a failure");

  a_nowrite_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.write_valid |-> out_data_r.last)
    else $error("non-write result not marked last");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

endmodule
`default_nettype wire
